// File: rtl/fsge_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fsge_pkg
// Shared types, sizes and codes of the falling-sand grid engine.
// ============================================================================
package fsge_pkg;

    // Grid geometry and tile type width
    localparam int GRID_ROWS = 128;
    localparam int GRID_COLS = 128;
    localparam int KIND_BITS = 3;

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = KIND_BITS + 32;

    typedef logic [KIND_BITS-1:0] t_kind;
    typedef logic [ADDR_W-1:0]    t_addr;

    localparam t_kind       KIND_AIR    = t_kind'(0);
    localparam t_kind       KIND_SAND   = t_kind'(1);
    localparam logic [31:0] COLOR_BLACK = 32'h0000_00FF;

    // One grid entry: type over packed RGBA colour
    typedef struct packed {
        t_kind       kind;
        logic [31:0] color;
    } t_cell;

    typedef enum logic [2:0] {
        MODE_STEP   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_READ   = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_RETYPE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        MOVE_NONE  = 2'd0,
        MOVE_DOWN  = 2'd1,
        MOVE_LEFT  = 2'd2,
        MOVE_RIGHT = 2'd3
    } t_move;

    // 3-bit port field to stored type (mask or zero-extend)
    function automatic t_kind kind_from_field(input logic [2:0] v);
        logic [KIND_BITS+2:0] ext;
        ext = {{KIND_BITS{1'b0}}, v};
        return ext[KIND_BITS-1:0];
    endfunction

    // Stored type to 3-bit port field
    function automatic logic [2:0] kind_to_field(input t_kind k);
        logic [KIND_BITS+2:0] ext;
        ext = {3'b000, k};
        return ext[2:0];
    endfunction

endpackage

// File: rtl/fsge_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// fsge_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ============================================================================
module fsge_ram #(
    parameter  int WIDTH = 35,
    parameter  int DEPTH = 16384,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/falling_sand_grid_engine_unit.sv
`timescale 1ns / 1ps
// A sand step reads its cell, the cell below and the two diagonal cells below; on a move
//   it writes the tile to the target and then blanks the source.
// Clear and retype both sweep one grid entry per cycle through the single RAM write port.
// One item at a time; the next is accepted the cycle after the result loads.
// Reset (synchronous, active low) starts a clearing pass over every grid entry, no item taken.
// ============================================================================
// falling_sand_grid_engine_unit
// Falling-sand grid engine: tile grid in one RAM, read-modify-write sequencer
// for cell steps, cell access, clearing and retyping sweeps.
// ============================================================================
module falling_sand_grid_engine_unit
    import fsge_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_column,
    input  logic [2:0]  i_tile_kind,
    input  logic [2:0]  i_match_kind,
    input  logic [31:0] i_tile_color,
    input  logic        i_choice,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_read_kind,
    output logic [31:0] o_read_color,
    output logic [1:0]  o_move_taken
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_HERE   = 11'b000_0000_0010,
        ST_BELOW  = 11'b000_0000_0100,
        ST_LEFT   = 11'b000_0000_1000,
        ST_RIGHT  = 11'b000_0001_0000,
        ST_DECIDE = 11'b000_0010_0000,
        ST_WSRC   = 11'b000_0100_0000,
        ST_CLEAR  = 11'b000_1000_0000,
        ST_RETYPE = 11'b001_0000_0000,
        ST_DRAIN  = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } t_state;

    localparam t_addr ADDR_LAST = t_addr'(CELLS - 1);
    localparam t_cell CELL_BLANK = '{kind: KIND_AIR, color: COLOR_BLACK};

    // registers
    t_state      r_state,      n_state;
    t_mode       r_mode,       n_mode;
    logic [6:0]  r_row,        n_row;
    logic [6:0]  r_col,        n_col;
    t_kind       r_kind,       n_kind;
    t_kind       r_match,      n_match;
    logic [31:0] r_color,      n_color;
    logic        r_choice,     n_choice;
    t_cell       r_here,       n_here;
    t_kind       r_below_kind, n_below_kind;
    t_kind       r_left_kind,  n_left_kind;
    t_addr       r_sweep,      n_sweep;
    logic        r_rt_pend,    n_rt_pend;
    t_addr       r_rt_addr,    n_rt_addr;
    logic        r_boot,       n_boot;
    logic [2:0]  r_res_kind,   n_res_kind;
    logic [31:0] r_res_color,  n_res_color;
    t_move       r_res_move,   n_res_move;
    logic        r_out_valid,  n_out_valid;
    logic [2:0]  r_out_kind,   n_out_kind;
    logic [31:0] r_out_color,  n_out_color;
    t_move       r_out_move,   n_out_move;

    // RAM port signals
    logic                rd_en;
    t_addr               rd_addr;
    logic [CELL_W-1:0]   rd_data;
    t_cell               rd_cell;
    logic                wr_en;
    t_addr               wr_addr;
    t_cell               wr_data;

    // address arithmetic of the held item
    logic        in_grid;
    logic        bottom;
    logic        has_left;
    logic        has_right;
    logic [31:0] idx32;
    logic [31:0] below32;
    logic [31:0] left32;
    logic [31:0] right32;
    t_addr       idx;
    t_addr       below;
    t_addr       left_addr;
    t_addr       right_addr;

    logic        accept_in;
    logic        take_out;

    assign in_grid   = (32'(r_row) < 32'(GRID_ROWS)) && (32'(r_col) < 32'(GRID_COLS));
    assign bottom    = (32'(r_row) == 32'(GRID_ROWS - 1));
    assign has_left  = (r_col != 7'd0);
    assign has_right = ((32'(r_col) + 32'd1) < 32'(GRID_COLS));

    assign idx32   = 32'(r_row) * 32'(GRID_COLS) + 32'(r_col);
    assign below32 = idx32 + 32'(GRID_COLS);
    assign left32  = below32 - 32'd1;
    assign right32 = below32 + 32'd1;

    assign idx        = idx32[ADDR_W-1:0];
    assign below      = below32[ADDR_W-1:0];
    assign left_addr  = left32[ADDR_W-1:0];
    assign right_addr = right32[ADDR_W-1:0];

    assign rd_cell = t_cell'(rd_data);

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign take_out   = r_out_valid && !i_out_stall;

    // sequencer: next state, RAM accesses, result
    always_comb begin
        logic  left_free;
        logic  right_free;
        t_move mv;
        t_addr dst;
        t_cell retyped;

        n_state      = r_state;
        n_mode       = r_mode;
        n_row        = r_row;
        n_col        = r_col;
        n_kind       = r_kind;
        n_match      = r_match;
        n_color      = r_color;
        n_choice     = r_choice;
        n_here       = r_here;
        n_below_kind = r_below_kind;
        n_left_kind  = r_left_kind;
        n_sweep      = r_sweep;
        n_rt_pend    = r_rt_pend;
        n_rt_addr    = r_rt_addr;
        n_boot       = r_boot;
        n_res_kind   = r_res_kind;
        n_res_color  = r_res_color;
        n_res_move   = r_res_move;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_color  = r_out_color;
        n_out_move   = r_out_move;

        rd_en   = 1'b0;
        rd_addr = idx;
        wr_en   = 1'b0;
        wr_addr = idx;
        wr_data = CELL_BLANK;

        // diagonal choice of a cell step
        left_free  = has_left && (r_left_kind == KIND_AIR);
        right_free = has_right && (rd_cell.kind == KIND_AIR);
        mv  = MOVE_NONE;
        dst = below;
        if (r_below_kind == KIND_AIR) begin
            mv  = MOVE_DOWN;
            dst = below;
        end else if (left_free && right_free) begin
            mv  = r_choice ? MOVE_RIGHT : MOVE_LEFT;
            dst = r_choice ? right_addr : left_addr;
        end else if (left_free) begin
            mv  = MOVE_LEFT;
            dst = left_addr;
        end else if (right_free) begin
            mv  = MOVE_RIGHT;
            dst = right_addr;
        end

        // entry as seen by a retype sweep
        retyped = rd_cell;
        if (rd_cell.kind == r_match) begin
            retyped.kind = r_kind;
        end

        if (take_out) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_mode   = t_mode'(i_mode);
                    n_row    = i_row;
                    n_col    = i_column;
                    n_kind   = kind_from_field(i_tile_kind);
                    n_match  = kind_from_field(i_match_kind);
                    n_color  = i_tile_color;
                    n_choice = i_choice;
                    n_state  = ST_HERE;
                end
            end
            ST_HERE: begin
                rd_en   = in_grid;
                rd_addr = idx;
                n_state = ST_BELOW;
            end
            ST_BELOW: begin
                // addressed cell is in rd_cell now
                n_here      = rd_cell;
                n_res_kind  = in_grid ? kind_to_field(rd_cell.kind) : 3'd0;
                n_res_color = in_grid ? rd_cell.color : 32'd0;
                n_res_move  = MOVE_NONE;
                n_state     = ST_DONE;
                unique case (r_mode)
                    MODE_STEP: begin
                        if (in_grid && !bottom && (rd_cell.kind == KIND_SAND)) begin
                            rd_en   = 1'b1;
                            rd_addr = below;
                            n_state = ST_LEFT;
                        end
                    end
                    MODE_WRITE: begin
                        wr_en   = in_grid;
                        wr_addr = idx;
                        wr_data = '{kind: r_kind, color: r_color};
                    end
                    MODE_CLEAR: begin
                        n_sweep = '0;
                        n_state = ST_CLEAR;
                    end
                    MODE_RETYPE: begin
                        n_sweep   = '0;
                        n_rt_pend = 1'b0;
                        n_state   = ST_RETYPE;
                    end
                    default: begin
                        // read and unused modes: report only
                    end
                endcase
            end
            ST_LEFT: begin
                n_below_kind = rd_cell.kind;
                rd_en        = has_left;
                rd_addr      = left_addr;
                n_state      = ST_RIGHT;
            end
            ST_RIGHT: begin
                n_left_kind = rd_cell.kind;
                rd_en       = has_right;
                rd_addr     = right_addr;
                n_state     = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_res_move = mv;
                if (mv != MOVE_NONE) begin
                    wr_en   = 1'b1;
                    wr_addr = dst;
                    wr_data = r_here;
                    n_state = ST_WSRC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WSRC: begin
                wr_en   = 1'b1;
                wr_addr = idx;
                wr_data = CELL_BLANK;
                n_state = ST_DONE;
            end
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                wr_data = CELL_BLANK;
                n_sweep = r_sweep + t_addr'(1);
                if (r_sweep == ADDR_LAST) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_DONE;
                end
            end
            ST_RETYPE: begin
                // read one entry ahead, write back the previous one
                rd_en     = 1'b1;
                rd_addr   = r_sweep;
                wr_en     = r_rt_pend;
                wr_addr   = r_rt_addr;
                wr_data   = retyped;
                n_rt_pend = 1'b1;
                n_rt_addr = r_sweep;
                n_sweep   = r_sweep + t_addr'(1);
                if (r_sweep == ADDR_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                wr_en   = 1'b1;
                wr_addr = r_rt_addr;
                wr_data = retyped;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || take_out) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_color = r_res_color;
                    n_out_move  = r_res_move;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_rt_pend   <= 1'b0;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_rt_pend   <= n_rt_pend;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_row        <= n_row;
        r_col        <= n_col;
        r_kind       <= n_kind;
        r_match      <= n_match;
        r_color      <= n_color;
        r_choice     <= n_choice;
        r_here       <= n_here;
        r_below_kind <= n_below_kind;
        r_left_kind  <= n_left_kind;
        r_rt_addr    <= n_rt_addr;
        r_res_kind   <= n_res_kind;
        r_res_color  <= n_res_color;
        r_res_move   <= n_res_move;
        r_out_kind   <= n_out_kind;
        r_out_color  <= n_out_color;
        r_out_move   <= n_out_move;
    end

    // tile grid
    fsge_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_kind  = r_out_kind;
    assign o_read_color = r_out_color;
    assign o_move_taken = r_out_move;

endmodule

// File: rtl/fsge_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fsge_checker
// Port-level assertions of the falling-sand grid engine, bound to the top.
// ============================================================================
module fsge_checker
    import fsge_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_read_kind,
    input logic [31:0] o_read_color,
    input logic [1:0]  o_move_taken
);

    // reset starts the clearing pass: no item taken, no result shown
    a_reset_busy: assert property (
        @(posedge i_clk) !i_rst_n |=> (o_in_stall && !o_out_valid)
    ) else $error("engine not busy and empty after reset");

    // one item at a time: an accepted item closes the input
    a_one_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input open right after an item was accepted");

    // only a sand tile can have moved
    a_move_is_sand: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_move_taken != MOVE_NONE))
            |-> (o_read_kind == kind_to_field(KIND_SAND))
    ) else $error("move reported for a tile that is not sand");

    // a stalled result holds
    a_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_read_kind) && $stable(o_read_color)
                 && $stable(o_move_taken))
    ) else $error("stalled result changed");

endmodule

bind falling_sand_grid_engine_unit fsge_checker u_fsge_checker (.*);
